/* rtl/plst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plst_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int MODE_W = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 3'd0,
    MODE_REMOVE  = 3'd1,
    MODE_READ    = 3'd2,
    MODE_REPLACE = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic             dir;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] bound;
  } step_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] nbr;
    logic             at_end;
  } step_res_t;

endpackage

`default_nettype wire

/* rtl/plst_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface plst_req_if;
  logic                        valid;
  logic                        ready;
  logic [plst_pkg::MODE_W-1:0] mode;
  logic [plst_pkg::POS_W-1:0]  position;
  logic [plst_pkg::VAL_W-1:0]  entry_value;

  modport source (output valid, output mode, output position, output entry_value,
                  input ready);
  modport sink (input valid, input mode, input position, input entry_value,
                output ready);
endinterface

`default_nettype wire

/* rtl/plst_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface plst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [plst_pkg::STAT_W-1:0] status;
  logic [plst_pkg::VAL_W-1:0]  read_value;
  logic [plst_pkg::LEN_W-1:0]  list_length;

  modport source (output valid, output status, output read_value, output list_length,
                  input ready);
  modport sink (input valid, input status, input read_value, input list_length,
                output ready);
endinterface

`default_nettype wire

/* rtl/positional_list_store_core.sv */
// Sequence, accept to result valid: clear, unused modes and errors go straight to DONE;
// read and replace pass through LOOK and FETCH; insert and remove alternate RUN and
// MOVE while entries are shifted, then go to DONE.
// Throughput: one request at a time; the next is accepted the cycle after the result
// is registered, later while an earlier result is held; each entry moved costs one
// RAM read and one RAM write through the shared index stepper.
// Reset clears the length, sequencer and result valid; entry storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_core (
  input  wire logic clk,
  input  wire logic rst,
  plst_req_if.sink   req,
  plst_rsp_if.source rsp
);

  localparam int CNT_W  = plst_pkg::CNT_W;
  localparam int ADDR_W = plst_pkg::ADDR_W;
  localparam int CMP_W  = plst_pkg::CMP_W;
  localparam int DW     = plst_pkg::DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_MOVE,
    S_LOOK,
    S_FETCH,
    S_DONE
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           idx;
  logic [CNT_W-1:0]           bound;
  logic                       dir;
  logic                       is_replace;
  logic [DW-1:0]              val;
  plst_pkg::status_t          pend_status;
  logic [DW-1:0]              pend_rv;
  logic                       out_valid;
  plst_pkg::status_t          out_status;
  logic [DW-1:0]              out_rv;
  logic [plst_pkg::LEN_W-1:0] out_len;

  state_t                     state_next;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           idx_next;
  logic [CNT_W-1:0]           bound_next;
  logic                       dir_next;
  logic                       is_replace_next;
  plst_pkg::status_t          pend_status_next;

  logic                accept;
  logic [CMP_W-1:0]    pos_x;
  logic [CMP_W-1:0]    cnt_x;
  logic                pos_zero;
  logic                ins_bad;
  logic                acc_bad;
  logic                full;
  logic [CNT_W-1:0]    pos_idx;

  plst_pkg::step_ctl_t step_ctl;
  plst_pkg::step_res_t step_res;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DW-1:0]       ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DW-1:0]       ram_rdata;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign pos_x    = CMP_W'(req.position);
  assign cnt_x    = CMP_W'(count);
  assign pos_zero = (req.position == '0);
  assign ins_bad  = pos_zero || (pos_x > (cnt_x + CMP_W'(1)));
  assign acc_bad  = pos_zero || (pos_x > cnt_x);
  assign full     = (count == CNT_W'(plst_pkg::DEPTH));
  assign pos_idx  = CNT_W'(pos_x - CMP_W'(1));

  assign step_ctl = '{dir: dir, idx: idx, bound: bound};

  plst_step u_step (
    .ctl (step_ctl),
    .res (step_res)
  );

  plst_ram #(
    .WIDTH (DW),
    .DEPTH (plst_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    dir_next         = 1'b0;
    is_replace_next  = 1'b0;
    idx_next         = pos_idx;
    bound_next       = count;
    count_next       = count;
    state_next       = S_DONE;
    pend_status_next = plst_pkg::ST_OK;
    unique case (plst_pkg::mode_t'(req.mode))
      plst_pkg::MODE_INSERT: begin
        if (ins_bad) begin
          pend_status_next = plst_pkg::ST_BAD_POS;
        end else if (full) begin
          pend_status_next = plst_pkg::ST_FULL;
        end else begin
          idx_next   = count;
          bound_next = pos_idx;
          count_next = count + CNT_W'(1);
          state_next = S_RUN;
        end
      end
      plst_pkg::MODE_REMOVE: begin
        if (acc_bad) begin
          pend_status_next = plst_pkg::ST_BAD_POS;
        end else begin
          dir_next   = 1'b1;
          count_next = count - CNT_W'(1);
          state_next = S_RUN;
        end
      end
      plst_pkg::MODE_READ, plst_pkg::MODE_REPLACE: begin
        if (acc_bad) begin
          pend_status_next = plst_pkg::ST_BAD_POS;
        end else begin
          is_replace_next = (req.mode == plst_pkg::MODE_REPLACE);
          state_next      = S_LOOK;
        end
      end
      plst_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = (state == S_RUN) ? step_res.nbr[ADDR_W-1:0] : idx[ADDR_W-1:0];
    unique case (state)
      S_RUN: begin
        if (step_res.at_end && !dir) begin
          ram_we    = 1'b1;
          ram_wdata = val;
        end
      end
      S_MOVE: begin
        ram_we = 1'b1;
      end
      S_FETCH: begin
        if (is_replace) begin
          ram_we    = 1'b1;
          ram_wdata = val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dir         <= dir_next;
            is_replace  <= is_replace_next;
            val         <= DW'(req.entry_value);
            pend_rv     <= '0;
            pend_status <= pend_status_next;
            idx         <= idx_next;
            bound       <= bound_next;
            count       <= count_next;
            state       <= state_next;
          end
        end
        S_RUN: begin
          state <= step_res.at_end ? S_DONE : S_MOVE;
        end
        S_MOVE: begin
          idx   <= step_res.nbr;
          state <= S_RUN;
        end
        S_LOOK: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          pend_rv <= ram_rdata;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= pend_status;
            out_rv     <= pend_rv;
            out_len    <= plst_pkg::LEN_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = plst_pkg::VAL_W'(out_rv);
  assign rsp.list_length = out_len;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(plst_pkg::DEPTH))
    else $error("list length above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !accept) |=> $stable(count))
    else $error("list length changed without a request");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.mode == plst_pkg::MODE_CLEAR)) |=> (count == '0))
    else $error("clear left entries");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_RUN) || (state == S_MOVE) || (state == S_FETCH)))
    else $error("storage write outside a write step");

  a_move_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (idx < CNT_W'(plst_pkg::DEPTH)))
    else $error("shift address out of range");

endmodule

`default_nettype wire

/* rtl/plst_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/plst_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module plst_step (
  input  wire plst_pkg::step_ctl_t ctl,
  output plst_pkg::step_res_t      res
);

  logic [plst_pkg::CNT_W-1:0] nbr;

  // step toward the far end of the shift; stop when the bound is reached
  always_comb begin
    nbr = ctl.dir ? (ctl.idx + plst_pkg::CNT_W'(1)) : (ctl.idx - plst_pkg::CNT_W'(1));
    res.nbr = nbr;
    res.at_end = ((ctl.dir ? nbr : ctl.idx) == ctl.bound);
  end

endmodule

`default_nettype wire

/* tb/sv/positional_list_checker.sv */
`timescale 1ns / 1ps

module positional_list_checker (
  input  logic clk,
  input  logic rst,
  plst_req_if  req,
  plst_rsp_if  rsp,
  output int   fail_count,
  output int   answers_owed
);
  import plst_pkg::*;

  typedef struct {
    status_t              status;
    logic [VAL_W-1:0]     read_value;
    logic [LEN_W-1:0]     list_length;
  } answer_t;

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int                    fill;
  answer_t               answer_q [$];

  initial begin
    fail_count   = 0;
    answers_owed = 0;
    fill         = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, seen, wanted);
    fail_count++;
  endtask

  task automatic apply_list_op(input logic [MODE_W-1:0] mode,
                               input logic [POS_W-1:0] position,
                               input logic [VAL_W-1:0] entry_value,
                               output answer_t ans);
    int p;
    p = int'(position);
    ans.status     = ST_OK;
    ans.read_value = '0;
    case (mode)
      MODE_INSERT: begin
        if (p < 1 || p > fill + 1) begin
          ans.status = ST_BAD_POS;
        end else if (fill >= DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = fill; i >= p; i--) slots[i] = slots[i-1];
          slots[p-1] = entry_value[DATA_WIDTH-1:0];
          fill++;
        end
      end
      MODE_REMOVE: begin
        if (p < 1 || p > fill) begin
          ans.status = ST_BAD_POS;
        end else begin
          for (int i = p - 1; i + 1 < fill; i++) slots[i] = slots[i+1];
          fill--;
        end
      end
      MODE_READ: begin
        if (p < 1 || p > fill) ans.status = ST_BAD_POS;
        else ans.read_value = VAL_W'(slots[p-1]);
      end
      MODE_REPLACE: begin
        if (p < 1 || p > fill) begin
          ans.status = ST_BAD_POS;
        end else begin
          ans.read_value = VAL_W'(slots[p-1]);
          slots[p-1]     = entry_value[DATA_WIDTH-1:0];
        end
      end
      MODE_CLEAR: fill = 0;
      default: ;
    endcase
    ans.list_length = LEN_W'(fill);
  endtask

  always @(posedge clk) begin
    answer_t want;
    answer_t fresh;
    if (rst) begin
      fill = 0;
      answer_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("word with nothing outstanding", 64'(rsp.read_value), 64'd0);
        end else begin
          want = answer_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", 64'(rsp.read_value), 64'(want.read_value));
          if (rsp.list_length !== want.list_length)
            report_mismatch("list_length", 64'(rsp.list_length), 64'(want.list_length));
        end
      end
      if (req.valid && req.ready) begin
        apply_list_op(req.mode, req.position, req.entry_value, fresh);
        answer_q.push_back(fresh);
      end
    end
    answers_owed <= answer_q.size();
  end

endmodule

/* tb/sv/tb_positional_list_store_core.sv */
`timescale 1ns / 1ps

module tb_positional_list_store_core;
  import plst_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 250;
  localparam int NOISE_PCT    = 12;
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd5;

  logic clk;
  logic rst;
  int   gap_pct;
  int   stall_pct;
  int   shadow_len;
  int   cycle_count = 0;
  int   fail_count;
  int   answers_owed;

  plst_req_if req ();
  plst_rsp_if rsp ();

  positional_list_store_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  positional_list_checker watch (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .answers_owed (answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [POS_W-1:0] position,
                              input logic [VAL_W-1:0] entry_value);
    int p;
    p = int'(position);
    while ($urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= mode;
    req.position    <= position;
    req.entry_value <= entry_value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    case (mode)
      MODE_INSERT:  if (p >= 1 && p <= shadow_len + 1 && shadow_len < DEPTH) shadow_len++;
      MODE_REMOVE:  if (p >= 1 && p <= shadow_len) shadow_len--;
      MODE_CLEAR:   shadow_len = 0;
      default: ;
    endcase
  endtask

  // hold the sender until every word has come back
  task automatic drain_list;
    req.valid <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
  endtask

  task automatic send_random_item(input bit filling, output bit counted);
    int                roll;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    roll = $urandom_range(99);
    if (roll < (filling ? 45 : 22)) mode = MODE_INSERT;
    else if (roll < (filling ? 60 : 57)) mode = MODE_REMOVE;
    else if (roll < 76) mode = MODE_READ;
    else if (roll < 97) mode = MODE_REPLACE;
    else if (roll < 98) mode = MODE_CLEAR;
    else mode = MODE_SPARE + MODE_W'($urandom_range(2));
    if ($urandom_range(99) < NOISE_PCT) position = POS_W'($urandom_range(63));
    else if (mode == MODE_INSERT) position = POS_W'($urandom_range(shadow_len + 1, 1));
    else if (shadow_len == 0) position = POS_W'($urandom_range(63));
    else position = POS_W'($urandom_range(shadow_len, 1));
    counted = (mode <= MODE_CLEAR);
    send_request(mode, position, $urandom());
  endtask

  initial begin
    int n;
    bit counted;
    int gaps [4];
    int stalls [4];
    gaps   = '{0, 73, 0, 15};
    stalls = '{0, 0, 73, 15};
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.mode        <= MODE_INSERT;
    req.position    <= '0;
    req.entry_value <= '0;
    gap_pct    = 0;
    stall_pct  = 0;
    shadow_len = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(MODE_CLEAR, POS_W'(0), '0);
    send_request(MODE_READ, POS_W'(1), '0);
    send_request(MODE_INSERT, POS_W'(0), 32'h1111_1111);
    send_request(MODE_INSERT, POS_W'(2), 32'h2222_2222);
    for (int k = 0; k < DEPTH; k++) begin
      send_request(MODE_INSERT,
                   (k % 3 == 0) ? POS_W'(1) :
                   (k % 3 == 1) ? POS_W'(shadow_len + 1) : POS_W'(shadow_len / 2 + 1),
                   (k == 0) ? '0 : (k == 1) ? '1 : $urandom());
    end
    send_request(MODE_INSERT, POS_W'(DEPTH + 1), 32'hDEAD_BEEF);
    send_request(MODE_INSERT, POS_W'(1), 32'hFEED_F00D);
    send_request(MODE_READ, POS_W'(DEPTH), '0);
    send_request(MODE_READ, POS_W'(DEPTH + 1), '0);
    send_request(MODE_REPLACE, POS_W'(1), '1);
    send_request(MODE_REPLACE, POS_W'(0), 32'h5A5A_5A5A);
    send_request(MODE_REMOVE, POS_W'(DEPTH), '0);
    send_request(MODE_REMOVE, '1, '0);
    send_request(MODE_READ, POS_W'(0), '0);
    for (int k = 0; k < 3; k++) send_request(MODE_SPARE + MODE_W'(k), '1, '1);
    send_request(MODE_CLEAR, '1, '1);
    send_request(MODE_REMOVE, POS_W'(1), '0);
    drain_list();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = gaps[ph];
      stall_pct = stalls[ph];
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_random_item(((n / 60) % 2) == 0, counted);
        if (counted) n++;
      end
      drain_list();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/plst_pkg.sv
rtl/plst_req_if.sv
rtl/plst_rsp_if.sv
rtl/plst_ram.sv
rtl/plst_step.sv
rtl/positional_list_store_core.sv
tb/sv/positional_list_checker.sv
tb/sv/tb_positional_list_store_core.sv
